FILE: rtl/core/can_frame_mask_matcher_top_assert.svh
// Assertion macros used by the checker file of the frame matcher.
`ifndef CAN_FRAME_MASK_MATCHER_TOP_ASSERT_SVH
`define CAN_FRAME_MASK_MATCHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cfmm_pkg.sv
`default_nettype none

package cfmm_pkg;

    localparam int IDENT_W     = 29;
    localparam int LEN_W       = 4;
    localparam int FIELD_BYTES = 8;
    localparam int FIELD_W     = 8 * FIELD_BYTES;
    localparam int INDEX_W     = 3;

    localparam logic [LEN_W-1:0] PAYLOAD_BYTES = 4'd8;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [LEN_W-1:0]   offset;
        logic [LEN_W-1:0]   len;
        logic [FIELD_W-1:0] mask_bytes;
        logic [FIELD_W-1:0] expect_bytes;
        logic               wait_flag;
    } entry_t;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [FIELD_W-1:0] payload;
        logic [LEN_W-1:0]   len;
    } frame_t;

endpackage

`default_nettype wire

FILE: rtl/core/cfmm_table.sv
`default_nettype none

module cfmm_table #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  wire                    clk,
    input  wire                    wr_en,
    input  wire  [ADDR_W-1:0]      wr_addr,
    input  cfmm_pkg::entry_t       wr_data,
    input  wire  [ADDR_W-1:0]      rd_addr,
    output cfmm_pkg::entry_t       rd_data
);

    cfmm_pkg::entry_t mem [DEPTH];
    cfmm_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cfmm_cmp.sv
`default_nettype none

module cfmm_cmp (
    input  cfmm_pkg::entry_t ent,
    input  cfmm_pkg::frame_t frame,
    output logic             hit
);

    logic                          ident_eq;
    logic                          fits;
    logic                          bytes_ok;
    logic [cfmm_pkg::FIELD_W-1:0]  shifted;

    assign ident_eq = (ent.ident == frame.ident);
    assign fits     = ({1'b0, frame.len} >= ({1'b0, ent.offset} + {1'b0, ent.len}));
    assign shifted  = frame.payload >> {ent.offset, 3'b000};

    always_comb
    begin
        bytes_ok = 1'b1;
        for (int j = 0; j < cfmm_pkg::FIELD_BYTES; j++)
        begin
            if ((cfmm_pkg::LEN_W'(j) < ent.len) &&
                ((shifted[8*j +: 8] & ent.mask_bytes[8*j +: 8]) !=
                 ent.expect_bytes[8*j +: 8]))
            begin
                bytes_ok = 1'b0;
            end
        end
    end

    assign hit = ident_eq && (!ent.wait_flag || (fits && bytes_ok));

endmodule

`default_nettype wire

FILE: rtl/core/can_frame_mask_matcher_top.sv
// Acceptance filter for CAN frames with a data mask. A load request writes one
// table entry and returns found = 0 through the done state and the output
// register. A match request reads the table one entry per cycle, starting at
// the given index, and checks each entry in a single shared comparison unit;
// its result passes through the done state into the output register. The
// table memory's single read port sets this pace. The block takes one
// request at a time, but the finished result sits in an output register, so
// the next request is taken while it waits. The entry count register is
// written through its own port and must only change while the block is
// idle. Searching an entry that was never loaded gives an undefined result.
`default_nettype none

module can_frame_mask_matcher_top #(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [3:0]  cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         req_type,
    input  wire  [2:0]  index,
    input  wire  [28:0] entry_ident,
    input  wire  [3:0]  byte_offset,
    input  wire  [3:0]  mask_len,
    input  wire  [63:0] mask_bytes,
    input  wire  [63:0] expect_bytes,
    input  wire         wait_flag,
    input  wire  [28:0] frame_ident,
    input  wire  [63:0] payload,
    input  wire  [3:0]  payload_len,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        found,
    output logic [2:0]  match_index
);

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_ENTRIES);

    cfmm_pkg::state_t state_reg, state_next;
    logic [CMP_W-1:0] ptr_reg, ptr_next;
    cfmm_pkg::frame_t frame_reg, frame_next;
    logic             res_found_reg, res_found_next;
    logic [2:0]       res_idx_reg, res_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [2:0]       out_idx_reg, out_idx_next;
    logic [3:0]       entries_in_use_reg, entries_in_use_next;

    logic             accept;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] in_use_ext;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] ptr_inc;
    logic [3:0]       plen_sat;
    logic             wr_en;
    cfmm_pkg::entry_t wr_data;
    cfmm_pkg::entry_t rd_data;
    logic             hit;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == cfmm_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign idx_ext    = CMP_W'(index);
    assign in_use_ext = CMP_W'(entries_in_use_reg);
    assign limit      = (in_use_ext > DEPTH_C) ? DEPTH_C : in_use_ext;
    assign ptr_inc    = ptr_reg + CMP_W'(1);
    assign plen_sat   = (payload_len > cfmm_pkg::PAYLOAD_BYTES) ?
                        cfmm_pkg::PAYLOAD_BYTES : payload_len;

    assign wr_en = accept && (req_type == cfmm_pkg::REQ_LOAD) && (idx_ext < DEPTH_C);

    assign wr_data.ident        = entry_ident;
    assign wr_data.offset       = byte_offset;
    assign wr_data.len          = mask_len;
    assign wr_data.mask_bytes   = mask_bytes;
    assign wr_data.expect_bytes = expect_bytes;
    assign wr_data.wait_flag    = wait_flag;

    cfmm_table #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_ext[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (ptr_next[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    cfmm_cmp u_cmp (
        .ent   (rd_data),
        .frame (frame_reg),
        .hit   (hit)
    );

    always_comb
    begin
        state_next          = state_reg;
        ptr_next            = ptr_reg;
        frame_next          = frame_reg;
        res_found_next      = res_found_reg;
        res_idx_next        = res_idx_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        out_found_next      = out_found_reg;
        out_idx_next        = out_idx_reg;
        entries_in_use_next = entries_in_use_reg;

        if (cfg_valid && cfg_ready)
        begin
            entries_in_use_next = cfg_data;
        end

        unique case (state_reg)
            cfmm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    frame_next.ident   = frame_ident;
                    frame_next.payload = payload;
                    frame_next.len     = plen_sat;
                    res_found_next     = 1'b0;
                    res_idx_next       = 3'd0;
                    ptr_next           = idx_ext;
                    if ((req_type == cfmm_pkg::REQ_MATCH) && (idx_ext < limit))
                    begin
                        state_next = cfmm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = cfmm_pkg::ST_DONE;
                    end
                end
            end
            cfmm_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_idx_next   = ptr_reg[2:0];
                    state_next     = cfmm_pkg::ST_DONE;
                end
                else if (ptr_inc >= limit)
                begin
                    state_next = cfmm_pkg::ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            cfmm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_idx_next   = res_idx_reg;
                    state_next     = cfmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= cfmm_pkg::ST_IDLE;
            out_valid_reg      <= 1'b0;
            entries_in_use_reg <= 4'd0;
        end
        else
        begin
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
            entries_in_use_reg <= entries_in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        frame_reg     <= frame_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign match_index = out_idx_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cfmm_checker.sv
`default_nettype none

`include "can_frame_mask_matcher_top_assert.svh"

module cfmm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire        found,
    input wire  [2:0] match_index
);

    `CFMM_ASSERT_NEXT(a_one_request_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")

    `CFMM_ASSERT_SAME(a_no_index_when_missed, out_valid && !found, match_index == 3'd0, "index set without a match")

    `CFMM_ASSERT_SAME(a_result_after_busy, $rose(out_valid), $past(!in_ready), "result appeared without a request in progress")

    `CFMM_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(found) && $stable(match_index), "stalled result changed")

endmodule

bind can_frame_mask_matcher_top cfmm_checker u_cfmm_checker (.*);

`default_nettype wire
